[rtl/core/prle_pkg.sv]
// Shared types and constants for the palette run-length encoder.
// No dependencies; every other file of the block uses it by scoped names.
package prle_pkg;

  localparam int FLOAT_W = 32;
  localparam int TAG_W   = 8;
  localparam int LEN_W   = 16;
  localparam int SLOT_W  = 8;
  localparam int MAT_W   = 5 * FLOAT_W + TAG_W;

  // record_kind codes
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_RUN   = 1'b1;

  typedef struct packed {
    logic [FLOAT_W-1:0] density;
    logic [FLOAT_W-1:0] strength;
    logic [FLOAT_W-1:0] conductivity;
    logic [FLOAT_W-1:0] porosity;
    logic [FLOAT_W-1:0] hardness;
    logic [TAG_W-1:0]   tag;
  } material_t;

  typedef struct packed {
    logic               record_kind;
    logic [LEN_W-1:0]   run_length;
    logic [SLOT_W-1:0]  palette_slot;
    material_t          mat;
    logic               overflow;
    logic               chunk_end;
    logic               last_of_item;
  } out_item_t;

endpackage

[rtl/core/prle_in_if.sv]
// Voxel input channel: valid/ready handshake plus one voxel material.
// Depends on prle_pkg for field widths.
interface prle_in_if;
  logic                         valid;
  logic                         ready;
  logic [prle_pkg::FLOAT_W-1:0] density_bits;
  logic [prle_pkg::FLOAT_W-1:0] strength_bits;
  logic [prle_pkg::FLOAT_W-1:0] conductivity_bits;
  logic [prle_pkg::FLOAT_W-1:0] porosity_bits;
  logic [prle_pkg::FLOAT_W-1:0] hardness_bits;
  logic [prle_pkg::TAG_W-1:0]   color_tag;
  logic                         final_voxel;

  modport source (
    output valid, density_bits, strength_bits, conductivity_bits, porosity_bits,
           hardness_bits, color_tag, final_voxel,
    input  ready
  );
  modport sink (
    input  valid, density_bits, strength_bits, conductivity_bits, porosity_bits,
           hardness_bits, color_tag, final_voxel,
    output ready
  );
endinterface

[rtl/core/prle_out_if.sv]
// Record output channel: valid/ready handshake plus one palette or run record.
// Depends on prle_pkg for field widths.
interface prle_out_if;
  logic                         valid;
  logic                         ready;
  logic                         record_kind;
  logic [prle_pkg::LEN_W-1:0]   run_length;
  logic [prle_pkg::SLOT_W-1:0]  palette_slot;
  logic [prle_pkg::FLOAT_W-1:0] out_density;
  logic [prle_pkg::FLOAT_W-1:0] out_strength;
  logic [prle_pkg::FLOAT_W-1:0] out_conductivity;
  logic [prle_pkg::FLOAT_W-1:0] out_porosity;
  logic [prle_pkg::FLOAT_W-1:0] out_hardness;
  logic [prle_pkg::TAG_W-1:0]   out_tag;
  logic                         overflow;
  logic                         chunk_end;
  logic                         last_of_item;

  modport source (
    output valid, record_kind, run_length, palette_slot, out_density, out_strength,
           out_conductivity, out_porosity, out_hardness, out_tag, overflow,
           chunk_end, last_of_item,
    input  ready
  );
  modport sink (
    input  valid, record_kind, run_length, palette_slot, out_density, out_strength,
           out_conductivity, out_porosity, out_hardness, out_tag, overflow,
           chunk_end, last_of_item,
    output ready
  );
endinterface

[rtl/core/prle_mem.sv]
// Palette store: single-port-write, single-port-read RAM, registered read.
// Depends on prle_pkg for the material type.
module prle_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  prle_pkg::material_t wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output prle_pkg::material_t rd_data
);

  prle_pkg::material_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/prle_match.sv]
// Material comparator: float equality on five fields plus tag equality.
// Depends on prle_pkg for the material type.
module prle_match (
  input  prle_pkg::material_t stored,
  input  prle_pkg::material_t probe,
  output logic                hit
);

  function automatic logic is_nan(input logic [prle_pkg::FLOAT_W-1:0] x);
    return x[prle_pkg::FLOAT_W-2:0] > 31'h7f80_0000;
  endfunction

  // Zeros of either sign compare equal; a NaN never does.
  function automatic logic float_eq(input logic [prle_pkg::FLOAT_W-1:0] a,
                                    input logic [prle_pkg::FLOAT_W-1:0] b);
    logic [prle_pkg::FLOAT_W-1:0] ab;
    ab = a | b;
    return !is_nan(a) && !is_nan(b) && ((a == b) || (ab[prle_pkg::FLOAT_W-2:0] == '0));
  endfunction

  assign hit = float_eq(stored.density, probe.density)
            && float_eq(stored.strength, probe.strength)
            && float_eq(stored.conductivity, probe.conductivity)
            && float_eq(stored.porosity, probe.porosity)
            && float_eq(stored.hardness, probe.hardness)
            && (stored.tag == probe.tag);

endmodule

[rtl/core/palette_run_length_encoder_unit.sv]
// Palette run-length encoder. One voxel item is taken at a time: it is
// searched linearly in the palette RAM, one stored entry per cycle through
// the RAM's single read port, then the palette and the open run are updated
// and zero to three records go out through an output register. The search
// stops early at the first match. A new material that finds the palette
// full sets the sticky overflow flag.
// The palette RAM needs no clearing after reset; the fill count guards it.
// Depends on prle_pkg, prle_in_if, prle_out_if, prle_mem and prle_match.
module palette_run_length_encoder_unit #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_RUN       = 32768
) (
  input  logic       clk,
  input  logic       rst,
  prle_in_if.sink    voxel,
  prle_out_if.source result
);

  localparam int SW = $clog2(PALETTE_DEPTH);
  localparam int UW = $clog2(PALETTE_DEPTH + 1);
  localparam int CW = $clog2(MAX_RUN + 1);
  localparam logic [UW-1:0] DEPTH_U   = UW'(PALETTE_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(PALETTE_DEPTH - 1);
  localparam logic [CW-1:0] MAX_C     = CW'(MAX_RUN);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]          state;
  prle_pkg::material_t mat;
  logic                fin_in;
  logic [UW-1:0]       issue_addr;
  logic                rd_valid;
  logic [SW-1:0]       rd_addr_q;
  logic                found;
  logic [SW-1:0]       hit_slot;

  logic [UW-1:0]       used;
  logic [SW-1:0]       run_slot;
  logic [CW-1:0]       run_count;
  logic                overflow_seen;

  logic [2:0]          pend;
  logic [CW-1:0]       close_len;
  logic [SW-1:0]       close_slot;
  logic [SW-1:0]       entry_slot;
  logic [CW-1:0]       fin_len;
  logic [SW-1:0]       fin_slot;

  logic                out_valid;
  prle_pkg::out_item_t out_q;

  prle_pkg::material_t rd_data;
  logic                mat_hit;
  logic                hit;
  logic                issue;
  logic                wr_en;

  logic                room;
  logic                close;
  logic                entry;
  logic [SW-1:0]       slot;
  logic [SW-1:0]       rslot;
  logic [CW-1:0]       rcount;

  logic                load;
  logic [2:0]          rem;
  prle_pkg::out_item_t next_rec;

  prle_mem #(
    .DEPTH  (PALETTE_DEPTH),
    .ADDR_W (SW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (used[SW-1:0]),
    .wr_data (mat),
    .rd_en   (issue),
    .rd_addr (issue_addr[SW-1:0]),
    .rd_data (rd_data)
  );

  prle_match u_match (
    .stored (rd_data),
    .probe  (mat),
    .hit    (mat_hit)
  );

  assign hit   = rd_valid && mat_hit;
  assign issue = (state == S_SEARCH) && !hit && (issue_addr != used);

  // Palette and run update for the searched item
  always_comb begin
    room  = used != DEPTH_U;
    close = (run_count != '0) && (!found || hit_slot != run_slot || run_count >= MAX_C);
    entry = !found && room;
    if (found) begin
      slot = hit_slot;
    end else if (room) begin
      slot = used[SW-1:0];
    end else begin
      slot = LAST_SLOT;
    end
    if (close || run_count == '0) begin
      rslot  = slot;
      rcount = CW'(1);
    end else begin
      rslot  = run_slot;
      rcount = run_count + CW'(1);
    end
  end

  assign wr_en = (state == S_DECIDE) && entry;

  // Pick the next pending record: close, then entry, then final run
  always_comb begin
    next_rec              = '0;
    next_rec.overflow     = overflow_seen;
    if (pend[0]) begin
      rem                   = pend & 3'b110;
      next_rec.record_kind  = prle_pkg::KIND_RUN;
      next_rec.run_length   = prle_pkg::LEN_W'(close_len);
      next_rec.palette_slot = prle_pkg::SLOT_W'(close_slot);
    end else if (pend[1]) begin
      rem                   = pend & 3'b100;
      next_rec.record_kind  = prle_pkg::KIND_ENTRY;
      next_rec.palette_slot = prle_pkg::SLOT_W'(entry_slot);
      next_rec.mat          = mat;
    end else begin
      rem                   = 3'b000;
      next_rec.record_kind  = prle_pkg::KIND_RUN;
      next_rec.run_length   = prle_pkg::LEN_W'(fin_len);
      next_rec.palette_slot = prle_pkg::SLOT_W'(fin_slot);
      next_rec.chunk_end    = 1'b1;
    end
    next_rec.last_of_item = rem == 3'b000;
  end

  assign load = (state == S_EMIT) && (!out_valid || result.ready);

  // Output register: load a record, hold it until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      out_q     <= next_rec;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_valid      <= 1'b0;
      used          <= '0;
      run_slot      <= '0;
      run_count     <= '0;
      overflow_seen <= 1'b0;
      pend          <= 3'b000;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (voxel.valid) begin
            mat.density      <= voxel.density_bits;
            mat.strength     <= voxel.strength_bits;
            mat.conductivity <= voxel.conductivity_bits;
            mat.porosity     <= voxel.porosity_bits;
            mat.hardness     <= voxel.hardness_bits;
            mat.tag          <= voxel.color_tag;
            fin_in           <= voxel.final_voxel;
            issue_addr       <= '0;
            rd_valid         <= 1'b0;
            state            <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            found    <= 1'b1;
            hit_slot <= rd_addr_q;
            rd_valid <= 1'b0;
            state    <= S_DECIDE;
          end else if (issue_addr == used) begin
            // every read came back without a match, or the palette is empty
            found    <= 1'b0;
            rd_valid <= 1'b0;
            state    <= S_DECIDE;
          end else begin
            rd_valid   <= 1'b1;
            rd_addr_q  <= issue_addr[SW-1:0];
            issue_addr <= issue_addr + UW'(1);
          end
        end
        S_DECIDE: begin
          overflow_seen <= overflow_seen | (!found && !room);
          pend          <= {fin_in, entry, close};
          close_len     <= run_count;
          close_slot    <= run_slot;
          entry_slot    <= used[SW-1:0];
          fin_len       <= rcount;
          fin_slot      <= rslot;
          if (fin_in) begin
            used      <= '0;
            run_count <= '0;
            run_slot  <= '0;
          end else begin
            used      <= used + UW'(entry);
            run_count <= rcount;
            run_slot  <= rslot;
          end
          if (fin_in || entry || close) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (load) begin
            pend <= rem;
            if (rem == 3'b000) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign voxel.ready = state == S_IDLE;

  assign result.valid            = out_valid;
  assign result.record_kind      = out_q.record_kind;
  assign result.run_length       = out_q.run_length;
  assign result.palette_slot     = out_q.palette_slot;
  assign result.out_density      = out_q.mat.density;
  assign result.out_strength     = out_q.mat.strength;
  assign result.out_conductivity = out_q.mat.conductivity;
  assign result.out_porosity     = out_q.mat.porosity;
  assign result.out_hardness     = out_q.mat.hardness;
  assign result.out_tag          = out_q.mat.tag;
  assign result.overflow         = out_q.overflow;
  assign result.chunk_end        = out_q.chunk_end;
  assign result.last_of_item     = out_q.last_of_item;

  a_read_in_fill: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> UW'(rd_addr_q) < used)
    else $error("palette read beyond fill count");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    run_count <= MAX_C)
    else $error("open run longer than the run limit");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    used <= DEPTH_U)
    else $error("palette fill count beyond depth");

  a_chunk_end: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.chunk_end |->
      result.record_kind == prle_pkg::KIND_RUN && result.last_of_item)
    else $error("chunk end on a record that is not the closing run");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("overflow flag dropped");

endmodule
